@@ rtl/core/hsc_pkg.sv @@
// Package with shared types and constants for the homing and centering sequencer.
package hsc_pkg;

    // Default widths of the span counter and the tick timer
    localparam int SPAN_BITS_DEF  = 20;
    localparam int TIMER_BITS_DEF = 20;

    // Fixed field widths
    localparam int HALF_W   = 16;
    localparam int PAUSE_W  = 20;
    localparam int CHUNK_W  = 8;
    localparam int SPAN_W   = 20;
    localparam int PHASE_W  = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 20;
    localparam int S_DATA_W   = 8;
    localparam int M_DATA_W   = 32;

    // Register reset values
    localparam logic [HALF_W-1:0]  HALF_RST  = 16'd1000;
    localparam logic [PAUSE_W-1:0] PAUSE_RST = 20'd100000;
    localparam logic [CHUNK_W-1:0] CHUNK_RST = 8'd10;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_PERIOD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PAUSE       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CHUNK       = 2'd2;

    // Sequencer phase codes
    typedef enum logic [PHASE_W-1:0] {
        PH_IDLE      = 3'd0,
        PH_SEEK_LEFT = 3'd1,
        PH_PAUSE     = 3'd2,
        PH_SEEK_RIGHT = 3'd3,
        PH_CENTER    = 3'd4,
        PH_DONE      = 3'd5
    } phase_t;

    // Step pulse progress codes
    typedef enum logic [1:0] {
        PULSE_NONE = 2'd0,
        PULSE_HIGH = 2'd1,
        PULSE_LOW  = 2'd2
    } pulse_t;

    // Configuration values seen by the sequencer
    typedef struct packed {
        logic [HALF_W-1:0]  half_period_ticks;
        logic [PAUSE_W-1:0] pause_ticks;
        logic [CHUNK_W-1:0] chunk_steps;
    } cfg_t;

    // One registered tick item
    typedef struct packed {
        logic valid;
        logic start_req;
        logic left_switch_level;
        logic right_switch_level;
    } tick_t;

endpackage

@@ rtl/core/hsc_cfg_regs.sv @@
// Configuration register file for the homing and centering sequencer.
module hsc_cfg_regs
    import hsc_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg         = cfg_reg;

    // Write one register per transfer, drop unknown indexes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.half_period_ticks <= HALF_RST;
            cfg_reg.pause_ticks       <= PAUSE_RST;
            cfg_reg.chunk_steps       <= CHUNK_RST;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_HALF_PERIOD: cfg_reg.half_period_ticks <= cfg_data[HALF_W-1:0];
                CFG_PAUSE:       cfg_reg.pause_ticks       <= cfg_data[PAUSE_W-1:0];
                CFG_CHUNK:       cfg_reg.chunk_steps       <= cfg_data[CHUNK_W-1:0];
                default: ;
            endcase
        end
    end

endmodule

@@ rtl/core/hsc_input_stage.sv @@
// Input register stage that captures one tick item per transfer.
module hsc_input_stage
    import hsc_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,
    input  logic                take,
    output tick_t               tick
);

    logic valid_reg;
    logic start_reg;
    logic left_reg;
    logic right_reg;

    // Accept when empty or when the held item moves on this cycle
    assign s_tready = !valid_reg || take;
    assign tick     = {valid_reg, start_reg, left_reg, right_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            valid_reg <= 1'b1;
        end else if (take) begin
            valid_reg <= 1'b0;
        end
    end

    // Hold payload until the next transfer
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            start_reg <= s_tdata[0];
            left_reg  <= s_tdata[1];
            right_reg <= s_tdata[2];
        end
    end

endmodule

@@ rtl/core/hsc_sequencer.sv @@
// Sequencer state, next-state logic and result register.
module hsc_sequencer
    import hsc_pkg::*;
#(
    parameter int SPAN_BITS  = SPAN_BITS_DEF,
    parameter int TIMER_BITS = TIMER_BITS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  cfg_t                cfg,
    input  tick_t               tick,
    output logic                take,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata
);

    localparam logic [SPAN_BITS-1:0] SPAN_MAX = {SPAN_BITS{1'b1}};

    phase_t                phase_reg, phase_next;
    pulse_t                pulse_reg, pulse_next;
    logic [SPAN_BITS-1:0]  span_reg, span_next;
    logic [SPAN_BITS-1:0]  remain_reg, remain_next;
    logic [TIMER_BITS-1:0] timer_reg, timer_next;
    logic                  dir_reg, dir_next;

    logic                  out_valid_reg;
    logic [M_DATA_W-1:0]   out_data_reg;

    logic                  decide;
    logic                  left_pressed;
    logic                  right_pressed;
    logic [HALF_W-1:0]     half_m1;
    logic [TIMER_BITS-1:0] half_time;
    logic [CHUNK_W-1:0]    chunk;
    logic [SPAN_BITS:0]    span_sum;
    logic [SPAN_BITS-1:0]  remain_base;

    // Advance when an item is held and the result register can take it
    assign take     = tick.valid && (!out_valid_reg || m_tready);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    assign left_pressed  = !tick.left_switch_level;
    assign right_pressed = !tick.right_switch_level;
    assign half_m1   = (cfg.half_period_ticks == '0) ? '0 : cfg.half_period_ticks - 1'b1;
    assign half_time = TIMER_BITS'(half_m1);
    assign chunk     = (cfg.chunk_steps == '0) ? CHUNK_W'(1) : cfg.chunk_steps;
    assign span_sum  = {1'b0, span_reg} + (SPAN_BITS + 1)'(chunk);

    // Next state for one tick
    always_comb begin
        phase_next  = phase_reg;
        pulse_next  = pulse_reg;
        span_next   = span_reg;
        remain_next = remain_reg;
        timer_next  = timer_reg;
        dir_next    = dir_reg;
        decide      = 1'b0;
        remain_base = remain_reg;

        // Step pulse timing
        unique case (pulse_reg)
            PULSE_HIGH: begin
                if (timer_reg != '0) begin
                    timer_next = timer_reg - TIMER_BITS'(1);
                end else begin
                    pulse_next = PULSE_LOW;
                    timer_next = half_time;
                end
            end
            PULSE_LOW: begin
                if (timer_reg != '0) begin
                    timer_next = timer_reg - TIMER_BITS'(1);
                end else begin
                    pulse_next = PULSE_NONE;
                    decide     = 1'b1;
                end
            end
            default: begin
                pulse_next = PULSE_NONE;
                decide     = 1'b1;
            end
        endcase

        // Phase decisions on ticks with no pulse in progress
        if (decide) begin
            unique case (phase_reg)
                PH_SEEK_LEFT: begin
                    if (left_pressed) begin
                        phase_next = PH_PAUSE;
                        timer_next = TIMER_BITS'(cfg.pause_ticks);
                    end else begin
                        pulse_next = PULSE_HIGH;
                        timer_next = half_time;
                    end
                end
                PH_PAUSE: begin
                    if (timer_reg != '0) begin
                        timer_next = timer_reg - TIMER_BITS'(1);
                    end else begin
                        phase_next  = PH_SEEK_RIGHT;
                        dir_next    = 1'b0;
                        remain_next = '0;
                    end
                end
                PH_SEEK_RIGHT: begin
                    if (right_pressed) begin
                        remain_next = span_reg >> 1;
                        dir_next    = (span_reg >> 1) != '0;
                        phase_next  = PH_CENTER;
                    end else begin
                        // Start a new chunk and grow the span, saturating
                        if (remain_reg == '0) begin
                            span_next   = span_sum[SPAN_BITS] ? SPAN_MAX
                                                              : span_sum[SPAN_BITS-1:0];
                            remain_base = SPAN_BITS'(chunk);
                        end
                        remain_next = remain_base - SPAN_BITS'(1);
                        pulse_next  = PULSE_HIGH;
                        timer_next  = half_time;
                    end
                end
                PH_CENTER: begin
                    if (remain_reg == '0 || left_pressed) begin
                        phase_next = PH_DONE;
                    end else begin
                        remain_next = remain_reg - SPAN_BITS'(1);
                        pulse_next  = PULSE_HIGH;
                        timer_next  = half_time;
                    end
                end
                PH_IDLE, PH_DONE: begin
                    if (tick.start_req) begin
                        phase_next  = PH_SEEK_LEFT;
                        span_next   = '0;
                        remain_next = '0;
                        timer_next  = '0;
                        dir_next    = 1'b1;
                    end
                end
                default: begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    // Hold state and the result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_IDLE;
            pulse_reg     <= PULSE_NONE;
            span_reg      <= '0;
            remain_reg    <= '0;
            timer_reg     <= '0;
            dir_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (take) begin
                phase_reg     <= phase_next;
                pulse_reg     <= pulse_next;
                span_reg      <= span_next;
                remain_reg    <= remain_next;
                timer_reg     <= timer_next;
                dir_reg       <= dir_next;
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload: step, direction, phase, span
    always_ff @(posedge aclk) begin
        if (take) begin
            out_data_reg <= {7'd0,
                             SPAN_W'(span_next),
                             phase_next,
                             dir_next,
                             pulse_next == PULSE_HIGH};
        end
    end

endmodule

@@ rtl/core/stepper_homing_centering_sequencer_core.sv @@
// Top level of the stepper homing and centering sequencer.
//
//  channel   direction  handshake            payload
//  s_        in         s_tvalid/s_tready    s_tdata  (one tick item)
//  m_        out        m_tvalid/m_tready    m_tdata  (state after the tick)
//  cfg_      in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One tick item enters per cycle while m_ is not stalled; it passes through the
// input register, then the result register, and ticks stream through at one per
// cycle without a stall. The state update in the sequencer sets the single-cycle
// rate. Reset is synchronous on aresetn low: phase returns to idle, span,
// counters and pulse clear, and the registers reload their default values.
// A stalled m_ side holds the result and backs the input stage up; the
// input stage still takes one more item while a result waits.
module stepper_homing_centering_sequencer_core
    import hsc_pkg::*;
#(
    parameter int SPAN_BITS  = SPAN_BITS_DEF,
    parameter int TIMER_BITS = TIMER_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // [0] start_req, [1] left_switch_level, [2] right_switch_level
    input  logic [S_DATA_W-1:0]   s_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [0] step_level, [1] direction, [4:2] phase, [24:5] span_steps
    output logic [M_DATA_W-1:0]   m_tdata,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t  cfg;
    tick_t tick;
    logic  take;

    hsc_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    hsc_input_stage u_in (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .take     (take),
        .tick     (tick)
    );

    hsc_sequencer #(
        .SPAN_BITS  (SPAN_BITS),
        .TIMER_BITS (TIMER_BITS)
    ) u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .tick     (tick),
        .take     (take),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule
